// File: hw/rtl/pwbd_pkg.sv
// Package for the pulse-width bit decoder: shared constants and the
// front-to-back command type. No dependencies.
package pwbd_pkg;

   localparam int TIME_BITS_DEF   = 48;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int CYCLE_BITS      = 24;
   localparam int BYTE_BITS       = 8;
   localparam int COUNT_BITS      = $clog2(BYTE_BITS);

   localparam logic [CYCLE_BITS-1:0] CYCLE_LIMIT_RESET = CYCLE_BITS'(250 * 1000);
   localparam logic [COUNT_BITS-1:0] LAST_BIT          = COUNT_BITS'(BYTE_BITS - 1);

   typedef struct packed {
      logic long_cycle;
      logic bit_value;
   } cmd_type;

endpackage

// File: hw/rtl/pwbd_front.sv
// Front end: accepts edge beats, keeps edge timestamps, measures the cycle
// and high time and classifies each falling edge. Uses pwbd_pkg.
module pwbd_front
   import pwbd_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_line_level,
   input  logic [TIME_BITS-1:0]  req_edge_time_ns,
   input  logic [CYCLE_BITS-1:0] max_cycle_ns,
   input  logic                  q_full,
   output logic                  q_push,
   output cmd_type               q_cmd
);

   logic                 accept;
   logic                 fall_valid_ff, fall_valid_in;
   logic [TIME_BITS-1:0] last_fall_ff, last_fall_in;
   logic [TIME_BITS-1:0] last_rise_ff, last_rise_in;
   logic [TIME_BITS-1:0] cycle_ff, cycle_in;
   logic [TIME_BITS-1:0] high_ff, high_in;
   logic [TIME_BITS-1:0] limit;

   assign req_stall = fall_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = fall_valid_ff && !q_full;

   assign limit           = TIME_BITS'(max_cycle_ns);
   assign q_cmd.long_cycle = cycle_ff >= limit;
   assign q_cmd.bit_value  = high_ff > (cycle_ff >> 1);

   always_comb begin
      last_fall_in  = last_fall_ff;
      last_rise_in  = last_rise_ff;
      cycle_in      = cycle_ff;
      high_in       = high_ff;
      fall_valid_in = fall_valid_ff && !q_push;
      if (accept) begin
         if (req_line_level) begin
            last_rise_in = req_edge_time_ns;
         end else begin
            last_fall_in  = req_edge_time_ns;
            cycle_in      = req_edge_time_ns - last_fall_ff;
            high_in       = req_edge_time_ns - last_rise_ff;
            fall_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fall_valid_ff <= 1'b0;
         last_fall_ff  <= '0;
         last_rise_ff  <= '0;
      end else begin
         fall_valid_ff <= fall_valid_in;
         last_fall_ff  <= last_fall_in;
         last_rise_ff  <= last_rise_in;
      end
   end

   always_ff @(posedge clock) begin
      cycle_ff <= cycle_in;
      high_ff  <= high_in;
   end

endmodule

// File: hw/rtl/pwbd_queue.sv
// Short command queue between front and back of the pulse-width bit
// decoder. Uses pwbd_pkg.
module pwbd_queue
   import pwbd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  cmd_type                    push_cmd,
   input  logic                       pop,
   output logic                       out_valid,
   output cmd_type                    out_cmd,
   output logic                       full,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   cmd_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign count     = count_ff;
   assign full      = count_ff == CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: hw/rtl/pwbd_back.sv
// Back end: assembles bits into bytes, MSB first, and holds the result in
// an output register. Uses pwbd_pkg.
module pwbd_back
   import pwbd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  cmd_type              q_cmd,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [BYTE_BITS-1:0] rsp_data_byte
);

   logic                  out_free;
   logic                  completes;
   logic [BYTE_BITS-1:0]  shifted;
   logic [COUNT_BITS-1:0] bit_count_ff, bit_count_in;
   logic [BYTE_BITS-1:0]  shift_ff, shift_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BYTE_BITS-1:0]  rsp_data_ff, rsp_data_in;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign completes = !q_cmd.long_cycle && (bit_count_ff == LAST_BIT);
   assign q_pop     = q_valid && (!completes || out_free);
   assign shifted   = {shift_ff[BYTE_BITS-2:0], q_cmd.bit_value};

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data_byte = rsp_data_ff;

   always_comb begin
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
      if (q_pop) begin
         priority if (q_cmd.long_cycle) begin
            bit_count_in = '0;
            shift_in     = '0;
         end else if (completes) begin
            bit_count_in = '0;
            shift_in     = '0;
            rsp_data_in  = shifted;
            rsp_valid_in = 1'b1;
         end else begin
            bit_count_in = bit_count_ff + 1'b1;
            shift_in     = shifted;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff <= '0;
         shift_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: hw/rtl/pulse_width_bit_decoder_core.sv
// Top level of the pulse-width bit decoder: cycle limit register, front,
// command queue and back. Uses pwbd_pkg, pwbd_front, pwbd_queue, pwbd_back.
//
// Usage:
//   req_*  : one beat per line edge, level after the edge plus a wrapping
//            nanosecond timestamp. Rising edges only record their time.
//   rsp_*  : one beat per completed byte, first bit in the MSB.
//   csr_*  : write of the cycle limit; write it only while the block is idle.
// Throughput: one edge beat per cycle while req_stall is low. The front
//   registers each measurement, the queue takes its command the next cycle
//   unless full, and the back retires one command per cycle unless a
//   command that completes a byte finds the output register held. A falling
//   edge that completes a byte passes the front, queue and output registers.
// Stall: rsp_stall holds the output register; commands then pile up in the
//   QUEUE_DEPTH-entry queue, and req_stall rises once it is full and the
//   front holds a measured falling edge.
// Reset: timestamps, bit count and partial byte clear, the queue empties and
//   the cycle limit returns to 250000 ns.
module pulse_width_bit_decoder_core
   import pwbd_pkg::*;
#(
   parameter int TIME_BITS   = TIME_BITS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_line_level,
   input  logic [TIME_BITS-1:0]  req_edge_time_ns,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [BYTE_BITS-1:0]  rsp_data_byte,
   input  logic                  csr_wr_en,
   input  logic [CYCLE_BITS-1:0] csr_wr_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CYCLE_BITS-1:0] max_cycle_ff, max_cycle_in;
   logic                  q_push;
   logic                  q_pop;
   logic                  q_full;
   logic                  q_valid;
   logic [CNT_W-1:0]      q_count;
   cmd_type               push_cmd;
   cmd_type               pop_cmd;

   assign max_cycle_in = csr_wr_en ? csr_wr_data : max_cycle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_cycle_ff <= CYCLE_LIMIT_RESET;
      end else begin
         max_cycle_ff <= max_cycle_in;
      end
   end

   pwbd_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_line_level   (req_line_level),
      .req_edge_time_ns (req_edge_time_ns),
      .max_cycle_ns     (max_cycle_ff),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_cmd            (push_cmd)
   );

   pwbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .pop       (q_pop),
      .out_valid (q_valid),
      .out_cmd   (pop_cmd),
      .full      (q_full),
      .count     (q_count)
   );

   pwbd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_cmd         (pop_cmd),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data_byte (rsp_data_byte)
   );

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (q_count == CNT_W'(QUEUE_DEPTH)))
      else $error("req_stall without a full queue");

   a_byte_from_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(q_pop))
      else $error("result beat without a queue pop");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (q_count != '0))
      else $error("pop from empty queue");

   a_limit_after_reset: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> (max_cycle_ff == CYCLE_LIMIT_RESET))
      else $error("cycle limit not at reset value");

endmodule

// File: tb/sv/pulse_width_bit_decoder_core_tb.sv
// Self-checking testbench for pulse_width_bit_decoder_core: drives edge beats,
// predicts decoded bytes in a small tracker class and checks every rsp beat.
// Depends on pwbd_pkg and the RTL of the decoder only.
`timescale 1ns / 100ps

typedef logic [pwbd_pkg::TIME_BITS_DEF-1:0] stamp_type;

class bit_decode_tracker;
   logic [pwbd_pkg::CYCLE_BITS-1:0] cycle_limit;
   stamp_type                       fall_at;
   stamp_type                       rise_at;
   int unsigned                     bits_held;
   logic [7:0]                      partial;
   logic [7:0]                      expected_bytes[$];
   int                              errors;

   function new();
      cycle_limit = pwbd_pkg::CYCLE_LIMIT_RESET;
      fall_at     = '0;
      rise_at     = '0;
      bits_held   = 0;
      partial     = '0;
      errors      = 0;
   endfunction

   function void set_limit(logic [pwbd_pkg::CYCLE_BITS-1:0] value);
      cycle_limit = value;
   endfunction

   function void note_edge(logic level, stamp_type stamp);
      stamp_type span;
      stamp_type high_span;
      if (level) begin
         rise_at = stamp;
      end else begin
         span = stamp - fall_at;
         if (span < stamp_type'(cycle_limit)) begin
            high_span = stamp - rise_at;
            partial   = {partial[6:0], high_span > (span >> 1)};
            bits_held++;
            if (bits_held == 8) begin
               expected_bytes.push_back(partial);
               partial   = '0;
               bits_held = 0;
            end
         end else begin
            partial   = '0;
            bits_held = 0;
         end
         fall_at = stamp;
      end
   endfunction

   function void check_byte(logic [7:0] got);
      logic [7:0] want;
      if (expected_bytes.size() == 0) begin
         $display("%0t: data_byte: expected none, actual %02h", $time, got);
         errors++;
      end else begin
         want = expected_bytes.pop_front();
         if (got !== want) begin
            $display("%0t: data_byte: expected %02h, actual %02h", $time, want, got);
            errors++;
         end
      end
   endfunction

   function int pending();
      return expected_bytes.size();
   endfunction
endclass

module pulse_width_bit_decoder_core_tb;
   import pwbd_pkg::*;

   localparam int DRAIN_CYCLES   = 8;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 4000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_line_level;
   stamp_type             req_edge_time_ns;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [BYTE_BITS-1:0]  rsp_data_byte;
   logic                  csr_wr_en;
   logic [CYCLE_BITS-1:0] csr_wr_data;

   bit_decode_tracker sb;
   stamp_type         fall_cursor;
   int unsigned       limit_now;
   int                edges_sent;
   bit                idle_on;
   bit                long_hold;
   int                quiet_cycles;

   pulse_width_bit_decoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_line_level   (req_line_level),
      .req_edge_time_ns (req_edge_time_ns),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data_byte    (rsp_data_byte),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_edge(req_line_level, req_edge_time_ns);
         if (rsp_valid && !rsp_stall)
            sb.check_byte(rsp_data_byte);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: random stall bursts, plus one long hold on request
   initial begin
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold = 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7) - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_edge(input logic level, input stamp_type stamp);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 7);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_line_level   <= level;
      req_edge_time_ns <= stamp;
      do @(posedge clock); while (req_stall);
      edges_sent++;
   endtask

   task automatic send_fall(input stamp_type stamp);
      send_edge(1'b0, stamp);
      fall_cursor = stamp;
   endtask

   task automatic send_bit_exact(input int unsigned span, input int unsigned high_len);
      send_edge(1'b1, fall_cursor + stamp_type'(span) - stamp_type'(high_len));
      send_fall(fall_cursor + stamp_type'(span));
   endtask

   task automatic send_bit(input bit one, input int unsigned span);
      int unsigned half;
      int unsigned high_len;
      half = span >> 1;
      if (one)
         high_len = $urandom_range(half + 1, (span > half + 1) ? span : half + 1);
      else
         high_len = $urandom_range(0, half);
      send_bit_exact(span, high_len);
   endtask

   function automatic int unsigned pick_cycle();
      int unsigned r;
      int unsigned cap;
      r   = $urandom_range(0, 39);
      cap = (limit_now > 3000) ? 3000 : limit_now;
      if (limit_now == 0)
         return $urandom_range(0, 3000);
      if (r == 0)
         return limit_now - 1;
      if (r == 1)
         return limit_now;
      if (r < 12)
         return $urandom_range(0, limit_now - 1);
      return $urandom_range(0, cap - 1);
   endfunction

   task automatic send_byte();
      repeat (8) send_bit($urandom_range(0, 1), pick_cycle());
   endtask

   task automatic run_random(input int target);
      int          r;
      int unsigned span;
      stamp_type   stamp;
      while (edges_sent < target) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            send_byte();
         end else if (r < 78) begin
            stamp = stamp_type'({$urandom, $urandom});
            if ($urandom_range(0, 1))
               send_edge(1'b1, stamp);
            else
               send_fall(stamp);
         end else if (r < 84) begin
            if ($urandom_range(0, 1)) begin
               send_edge(1'b1, fall_cursor + stamp_type'($urandom_range(0, 2000)));
               send_bit($urandom_range(0, 1), pick_cycle());
            end else begin
               send_bit($urandom_range(0, 1), pick_cycle());
               send_fall(fall_cursor + stamp_type'(pick_cycle()));
            end
         end else if (r < 90) begin
            send_fall(fall_cursor + stamp_type'(limit_now)
                      + stamp_type'($urandom_range(0, 1000)));
         end else if (r < 95) begin
            send_fall(stamp_type'(0) - stamp_type'($urandom_range(1, 20000)));
            send_byte();
         end else begin
            span = pick_cycle();
            send_edge(1'b1, fall_cursor + stamp_type'(span)
                      + stamp_type'($urandom_range(1, 1000)));
            send_fall(fall_cursor + stamp_type'(span));
         end
      end
   endtask

   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CYCLE_BITS-1:0] value);
      quiesce();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_limit(value);
      limit_now = value;
   endtask

   initial begin
      sb               = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_line_level   = 1'b0;
      req_edge_time_ns = '0;
      rsp_stall        = 1'b0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      fall_cursor      = '0;
      limit_now        = CYCLE_LIMIT_RESET;
      edges_sent       = 0;
      idle_on          = 1'b0;
      long_hold        = 1'b0;
      quiet_cycles     = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: first fall vs time zero, half-cycle boundary, repeated
      // levels, limit boundary, wrapped rise, long cycle, timestamp wrap
      send_fall(stamp_type'(100000));
      send_bit_exact(1000, 500);
      send_bit_exact(1001, 501);
      send_edge(1'b1, fall_cursor + stamp_type'(100));
      send_edge(1'b1, fall_cursor + stamp_type'(800));
      send_fall(fall_cursor + stamp_type'(1000));
      send_bit_exact(249999, 249999);
      send_bit_exact(0, 0);
      send_bit_exact(3000, 2999);
      send_edge(1'b1, fall_cursor + stamp_type'(2005));
      send_fall(fall_cursor + stamp_type'(2000));
      send_fall(fall_cursor + stamp_type'(300));
      send_fall(fall_cursor + stamp_type'(250000));
      send_fall('1);
      send_bit_exact(1000, 700);
      send_fall('0);

      idle_on = 1'b1;
      run_random(520);

      write_limit('0);
      run_random(620);

      write_limit('1);
      long_hold = 1'b1;
      run_random(800);
      run_random(1020);

      write_limit(CYCLE_BITS'(1));
      run_random(1120);

      write_limit(CYCLE_BITS'($urandom_range(2, 16777214)));
      run_random(1450);

      write_limit(CYCLE_BITS'(1000));
      idle_on = 1'b0;
      run_random(1800);

      quiesce();
      if (sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/pwbd_pkg.sv
hw/rtl/pwbd_front.sv
hw/rtl/pwbd_queue.sv
hw/rtl/pwbd_back.sv
hw/rtl/pulse_width_bit_decoder_core.sv
tb/sv/pulse_width_bit_decoder_core_tb.sv
